### sv/mqttfd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT frame detector package
// Sizes, byte codes and the running state record shared by the detector.
// ----------------------------------------------------------------------------
package mqttfd_pkg;

	localparam int FRAME_DEPTH = 512;
	localparam int CMD_DEPTH   = 256;
	localparam int BRACE_WIDTH = 16;

	localparam int FB_W      = $clog2(FRAME_DEPTH);
	localparam int CB_W      = $clog2(CMD_DEPTH);
	localparam int ACC_W     = 28;
	localparam int TOTAL_W   = 29;
	localparam int DIGIT_W   = 3;

	localparam logic [FB_W-1:0]    FRAME_MAX  = FB_W'(FRAME_DEPTH - 1);
	localparam logic [CB_W-1:0]    CMD_MAX    = CB_W'(CMD_DEPTH - 1);
	localparam logic [DIGIT_W-1:0] MAX_DIGITS = DIGIT_W'(4);

	localparam logic [7:0] CHAR_OPEN  = 8'h7B;
	localparam logic [7:0] CHAR_CLOSE = 8'h7D;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;

	typedef enum logic {
		CMD_BYTE    = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [FB_W-1:0]        frame_bytes;
		logic                   frame_done;
		logic [BRACE_WIDTH-1:0] brace_depth;
		logic [ACC_W-1:0]       length_accum;
		logic [DIGIT_W-1:0]     length_digits;
		logic                   length_complete;
		logic [TOTAL_W-1:0]     total_length;
		logic [CB_W-1:0]        cmd_bytes;
		logic                   cmd_ready;
	} det_state_t;

endpackage

### sv/mqttfd_next.sv
// ----------------------------------------------------------------------------
// MQTT frame detector next-state logic
// Applies one request (byte or release) to the running detector state.
// ----------------------------------------------------------------------------
module mqttfd_next (
	input  mqttfd_pkg::det_state_t cur,
	input  logic                   release_req,
	input  logic [7:0]             data_byte,
	input  logic                   transparent_mode,
	output mqttfd_pkg::det_state_t nxt
);

	logic                              fb_room;
	logic                              take;
	logic [mqttfd_pkg::ACC_W-1:0]      group;
	logic [mqttfd_pkg::DIGIT_W-1:0]    digits_base;
	logic [mqttfd_pkg::ACC_W-1:0]      accum_base;
	logic                              complete_base;
	logic [mqttfd_pkg::TOTAL_W-1:0]    total_base;

	always_comb begin
		nxt           = cur;
		fb_room       = cur.frame_bytes < mqttfd_pkg::FRAME_MAX;
		take          = 1'b0;
		group         = '0;
		digits_base   = cur.length_digits;
		accum_base    = cur.length_accum;
		complete_base = cur.length_complete;
		total_base    = cur.total_length;

		if (release_req) begin
			nxt.frame_bytes     = '0;
			nxt.frame_done      = 1'b0;
			nxt.cmd_bytes       = '0;
			nxt.cmd_ready       = 1'b0;
			nxt.length_accum    = '0;
			nxt.length_digits   = '0;
			nxt.length_complete = 1'b0;
			nxt.total_length    = '0;
		end else begin
			priority if (data_byte == mqttfd_pkg::CHAR_OPEN) begin
				nxt.brace_depth = cur.brace_depth + 1'b1;
			end else if (data_byte == mqttfd_pkg::CHAR_CLOSE) begin
				nxt.brace_depth = cur.brace_depth - 1'b1;
			end else begin
				nxt.brace_depth = cur.brace_depth;
			end

			if (fb_room) begin
				nxt.frame_bytes = cur.frame_bytes + 1'b1;
			end else begin
				nxt.frame_done = 1'b1;
			end

			if (nxt.frame_bytes == mqttfd_pkg::FB_W'(1)) begin
				digits_base   = '0;
				accum_base    = '0;
				complete_base = 1'b0;
				total_base    = '0;
			end

			take = !complete_base && (nxt.frame_bytes > mqttfd_pkg::FB_W'(1))
				&& (digits_base < mqttfd_pkg::MAX_DIGITS);

			unique case (digits_base[1:0])
				2'd0: group = mqttfd_pkg::ACC_W'(data_byte[6:0]);
				2'd1: group = mqttfd_pkg::ACC_W'(data_byte[6:0]) << 7;
				2'd2: group = mqttfd_pkg::ACC_W'(data_byte[6:0]) << 14;
				2'd3: group = mqttfd_pkg::ACC_W'(data_byte[6:0]) << 21;
				default: group = '0;
			endcase

			nxt.length_accum    = accum_base;
			nxt.length_digits   = digits_base;
			nxt.length_complete = complete_base;
			nxt.total_length    = total_base;

			if (take) begin
				nxt.length_accum  = accum_base | group;
				nxt.length_digits = digits_base + 1'b1;
				if (!data_byte[7]) begin
					nxt.length_complete = 1'b1;
					nxt.total_length    = mqttfd_pkg::TOTAL_W'(1)
						+ mqttfd_pkg::TOTAL_W'(nxt.length_digits)
						+ mqttfd_pkg::TOTAL_W'(nxt.length_accum);
				end
			end

			if (nxt.length_complete && (nxt.total_length != '0)
				&& (mqttfd_pkg::TOTAL_W'(nxt.frame_bytes) >= nxt.total_length)) begin
				nxt.frame_done = 1'b1;
			end

			if (transparent_mode && (data_byte == mqttfd_pkg::CHAR_CLOSE)
				&& (nxt.brace_depth == '0)) begin
				nxt.frame_done = 1'b1;
			end

			if (nxt.frame_bytes >= mqttfd_pkg::FRAME_MAX) begin
				nxt.frame_done = 1'b1;
			end

			if (cur.cmd_bytes < mqttfd_pkg::CMD_MAX) begin
				nxt.cmd_bytes = cur.cmd_bytes + 1'b1;
				if ((data_byte == mqttfd_pkg::CHAR_STAR)
					|| (nxt.cmd_bytes >= mqttfd_pkg::CMD_MAX)) begin
					nxt.cmd_ready = 1'b1;
				end
			end
		end
	end

endmodule

### sv/mqtt_serial_frame_detector_unit.sv
// ----------------------------------------------------------------------------
// MQTT serial frame detector
// Finds frame ends in a received byte stream from the MQTT remaining length,
// the frame buffer size or, in transparent mode, the JSON brace depth, and
// keeps a command byte count alongside.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while byte_stall is low and returns one
// result per request. An accepted request lands in an input register, the
// state update runs in one pass of logic and the result register holds the
// state after that request, which is offered as the result. The byte side stalls
// only while a result and a request are both held and the result side stalls.
// The mode register write is taken in any cycle; write it only while no
// request is in flight.
module mqtt_serial_frame_detector_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        transparent_mode,

	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic        command,
	input  logic [7:0]  data_byte,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  echo_byte,
	output logic [8:0]  frame_count,
	output logic        frame_end,
	output logic        length_known,
	output logic [28:0] packet_length,
	output logic [15:0] brace_level,
	output logic [7:0]  command_count,
	output logic        command_ready
);

	logic                   mode_q;
	logic                   valid_s1;
	mqttfd_pkg::cmd_t       command_s1;
	logic [7:0]             data_s1;
	logic                   valid_s2;
	logic [7:0]             echo_s2;
	mqttfd_pkg::det_state_t state_q;
	mqttfd_pkg::det_state_t state_next;
	logic                   adv_s2;
	logic                   accept_s1;
	logic                   release_s1;

	assign release_s1 = (command_s1 == mqttfd_pkg::CMD_RELEASE);
	assign adv_s2     = valid_s1 && (!valid_s2 || !result_stall);
	assign accept_s1  = byte_valid && !byte_stall;
	assign byte_stall = valid_s1 && !adv_s2;
	assign cfg_ready  = 1'b1;

	mqttfd_next u_next (
		.cur              (state_q),
		.release_req      (release_s1),
		.data_byte        (data_s1),
		.transparent_mode (mode_q),
		.nxt              (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= transparent_mode;
			end
			if (accept_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_s1) begin
			command_s1 <= mqttfd_pkg::cmd_t'(command);
			data_s1    <= data_byte;
		end
		if (adv_s2) begin
			echo_s2 <= release_s1 ? 8'd0 : data_s1;
		end
	end

	assign result_valid  = valid_s2;
	assign echo_byte     = echo_s2;
	assign frame_count   = 9'(state_q.frame_bytes);
	assign frame_end     = state_q.frame_done;
	assign length_known  = state_q.length_complete;
	assign packet_length = state_q.total_length;
	assign brace_level   = 16'(state_q.brace_depth);
	assign command_count = 8'(state_q.cmd_bytes);
	assign command_ready = state_q.cmd_ready;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("byte side stalled without a held result");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && release_s1) |=> (frame_count == 9'd0 && !frame_end
			&& !command_ready && !length_known && echo_byte == 8'd0))
		else $error("release left counts or flags set");

	a_length_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.length_complete |-> (state_q.length_digits != '0
			&& state_q.total_length != '0))
		else $error("length known without length bytes");

	a_frame_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.frame_bytes >= mqttfd_pkg::FRAME_MAX) |-> state_q.frame_done)
		else $error("full frame buffer without frame end");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// MQTT serial frame detector testbench
// Drives received bytes and release requests through the byte channel. A
// scoreboard predicts every result: frame byte count, the MQTT remaining
// length decode, brace depth and the command count. Results are checked field
// by field under random sender gaps, receiver stalls, a long receiver hold and
// both settings of transparent mode.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  echo;
		logic [8:0]  count;
		logic        fend;
		logic        known;
		logic [28:0] plen;
		logic [15:0] brace;
		logic [7:0]  ccount;
		logic        cready;
	} det_result_t;

	class frame_scoreboard;
		det_result_t pending[$];
		bit          mode;
		int          frame_bytes;
		bit          frame_done;
		logic [15:0] brace_depth;
		int unsigned length_accum;
		int          length_digits;
		bit          length_complete;
		int unsigned total_length;
		int          cmd_bytes;
		bit          cmd_ready;
		int          errors;
		int          n_checked;
		int          n_frame_end;
		int          n_known;
		int          n_full;
		int          n_cmd_ready;

		function void clear_length();
			length_accum    = 0;
			length_digits   = 0;
			length_complete = 0;
			total_length    = 0;
		endfunction

		function void note_request(mqttfd_pkg::cmd_t cmd, logic [7:0] d);
			det_result_t r;
			r.echo = 8'h00;
			if (cmd == mqttfd_pkg::CMD_RELEASE) begin
				frame_bytes = 0;
				frame_done  = 0;
				cmd_bytes   = 0;
				cmd_ready   = 0;
				clear_length();
			end else begin
				r.echo = d;
				if (d == mqttfd_pkg::CHAR_OPEN)
					brace_depth = brace_depth + 16'd1;
				else if (d == mqttfd_pkg::CHAR_CLOSE)
					brace_depth = brace_depth - 16'd1;
				if (frame_bytes < mqttfd_pkg::FRAME_DEPTH - 1)
					frame_bytes++;
				else
					frame_done = 1;
				if (frame_bytes == 1)
					clear_length();
				if (!length_complete && frame_bytes > 1 && length_digits < 4) begin
					length_accum += int'(d[6:0]) << (7 * length_digits);
					length_digits++;
					if (!d[7]) begin
						length_complete = 1;
						total_length    = 1 + length_digits + length_accum;
					end
				end
				if (length_complete && total_length > 0 && frame_bytes >= total_length)
					frame_done = 1;
				if (mode && d == mqttfd_pkg::CHAR_CLOSE && brace_depth == 16'd0)
					frame_done = 1;
				if (frame_bytes >= mqttfd_pkg::FRAME_DEPTH - 1)
					frame_done = 1;
				if (cmd_bytes < mqttfd_pkg::CMD_DEPTH - 1) begin
					cmd_bytes++;
					if (d == mqttfd_pkg::CHAR_STAR || cmd_bytes >= mqttfd_pkg::CMD_DEPTH - 1)
						cmd_ready = 1;
				end
			end
			r.count  = 9'(frame_bytes);
			r.fend   = frame_done;
			r.known  = length_complete;
			r.plen   = 29'(total_length);
			r.brace  = brace_depth;
			r.ccount = 8'(cmd_bytes);
			r.cready = cmd_ready;
			pending.push_back(r);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(det_result_t got);
			det_result_t want;
			if (pending.size() == 0) begin
				$error("result with no request waiting");
				errors++;
				return;
			end
			want = pending.pop_front();
			n_checked++;
			if (got.fend) n_frame_end++;
			if (got.known) n_known++;
			if (got.count == 9'(mqttfd_pkg::FRAME_DEPTH - 1)) n_full++;
			if (got.cready) n_cmd_ready++;
			compare("echo_byte", want.echo, got.echo);
			compare("frame_count", want.count, got.count);
			compare("frame_end", want.fend, got.fend);
			compare("length_known", want.known, got.known);
			compare("packet_length", want.plen, got.plen);
			compare("brace_level", want.brace, got.brace);
			compare("command_count", want.ccount, got.ccount);
			compare("command_ready", want.cready, got.cready);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        transparent_mode = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic        command = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  echo_byte;
	logic [8:0]  frame_count;
	logic        frame_end;
	logic        length_known;
	logic [28:0] packet_length;
	logic [15:0] brace_level;
	logic [7:0]  command_count;
	logic        command_ready;

	frame_scoreboard sb = new;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int long_hold = 0;
	int n_sent = 0;

	mqtt_serial_frame_detector_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.transparent_mode (transparent_mode),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.command          (command),
		.data_byte        (data_byte),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.echo_byte        (echo_byte),
		.frame_count      (frame_count),
		.frame_end        (frame_end),
		.length_known     (length_known),
		.packet_length    (packet_length),
		.brace_level      (brace_level),
		.command_count    (command_count),
		.command_ready    (command_ready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result({echo_byte, frame_count, frame_end, length_known,
					packet_length, brace_level, command_count, command_ready});
			if (long_hold > 0) begin
				result_stall <= 1'b1;
				long_hold--;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic offer(mqttfd_pkg::cmd_t cmd, logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		command    <= cmd;
		data_byte  <= d;
		do @(posedge clk); while (byte_stall);
		sb.note_request(cmd, d);
		n_sent++;
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		cfg_valid        <= 1'b1;
		transparent_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.mode = m;
	endtask

	function automatic logic [7:0] pick_payload();
		case ($urandom_range(15))
			0, 1:    return mqttfd_pkg::CHAR_OPEN;
			2, 3:    return mqttfd_pkg::CHAR_CLOSE;
			4:       return mqttfd_pkg::CHAR_STAR;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame();
		int nlen;
		int pay;
		bit hang;
		logic [7:0] b;
		offer(mqttfd_pkg::CMD_BYTE, 8'($urandom_range(255)));
		hang = ($urandom_range(7) == 0);
		nlen = hang ? 4 : (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1);
		b = 8'h00;
		for (int i = 0; i < nlen; i++) begin
			b = (nlen == 1) ? 8'($urandom_range(14)) : 8'($urandom_range(127));
			if (hang || i < nlen - 1)
				b[7] = 1'b1;
			offer(mqttfd_pkg::CMD_BYTE, b);
		end
		pay = (nlen == 1 && !hang) ? int'(b) + $urandom_range(2) : $urandom_range(12);
		repeat (pay) offer(mqttfd_pkg::CMD_BYTE, pick_payload());
		if ($urandom_range(7) != 0)
			offer(mqttfd_pkg::CMD_RELEASE, 8'($urandom_range(255)));
	endtask

	task automatic run_phase(int target);
		int start;
		start = n_sent;
		while (n_sent - start < target) begin
			if ($urandom_range(9) == 0)
				offer(mqttfd_pkg::cmd_t'($urandom_range(1)), pick_payload());
			else
				send_frame();
		end
	endtask

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(mqttfd_pkg::CMD_RELEASE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'h30);
		offer(mqttfd_pkg::CMD_BYTE, 8'h03);
		offer(mqttfd_pkg::CMD_BYTE, mqttfd_pkg::CHAR_STAR);
		offer(mqttfd_pkg::CMD_BYTE, 8'h00);
		offer(mqttfd_pkg::CMD_BYTE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'h7F);
		offer(mqttfd_pkg::CMD_RELEASE, 8'h00);
		offer(mqttfd_pkg::CMD_BYTE, 8'h10);
		offer(mqttfd_pkg::CMD_BYTE, 8'h80);
		offer(mqttfd_pkg::CMD_BYTE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'h80);
		offer(mqttfd_pkg::CMD_BYTE, 8'h81);
		offer(mqttfd_pkg::CMD_BYTE, 8'h05);
		offer(mqttfd_pkg::CMD_RELEASE, 8'h55);
		offer(mqttfd_pkg::CMD_BYTE, mqttfd_pkg::CHAR_CLOSE);
		offer(mqttfd_pkg::CMD_BYTE, mqttfd_pkg::CHAR_OPEN);
		offer(mqttfd_pkg::CMD_RELEASE, 8'hAA);
		write_mode(1'b1);
		offer(mqttfd_pkg::CMD_BYTE, 8'h30);
		offer(mqttfd_pkg::CMD_BYTE, mqttfd_pkg::CHAR_OPEN);
		offer(mqttfd_pkg::CMD_BYTE, mqttfd_pkg::CHAR_CLOSE);
		offer(mqttfd_pkg::CMD_RELEASE, 8'h00);
		offer(mqttfd_pkg::CMD_BYTE, 8'h20);
		offer(mqttfd_pkg::CMD_BYTE, 8'h7F);
		offer(mqttfd_pkg::CMD_RELEASE, 8'h00);

		// overfill both buffers behind a length far larger than either buffer
		offer(mqttfd_pkg::CMD_BYTE, 8'h30);
		offer(mqttfd_pkg::CMD_BYTE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'hFF);
		offer(mqttfd_pkg::CMD_BYTE, 8'h7F);
		repeat (520) offer(mqttfd_pkg::CMD_BYTE, pick_payload());
		offer(mqttfd_pkg::CMD_RELEASE, 8'h00);

		long_hold = 100;
		run_phase(30);
		wait_drained();
		run_phase(25);

		write_mode(1'b0);
		send_idle_pct = 48;
		run_phase(60);

		write_mode(1'b1);
		send_idle_pct = 0;
		stall_pct = 48;
		run_phase(60);

		write_mode(1'b0);
		send_idle_pct = 34;
		stall_pct = 34;
		run_phase(60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("tb: %0d requests, %0d results checked, both modes, four idling phases",
			n_sent, sb.n_checked);
		$display("tb: frame end %0d, length known %0d, buffer full %0d, command ready %0d",
			sb.n_frame_end, sb.n_known, sb.n_full, sb.n_cmd_ready);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
sv/mqttfd_pkg.sv
sv/mqttfd_next.sv
sv/mqtt_serial_frame_detector_unit.sv
tb/testbench.sv
